@@ design/nlis_pkg.sv @@
package nlis_pkg;

    localparam int INDEX_BITS     = 10;
    localparam int PRESCALE_BITS  = 8;
    localparam int SCALE_BITS     = 16;
    localparam int OFFSET_BITS    = INDEX_BITS + SCALE_BITS;
    localparam int ORDER_BITS     = 6;
    localparam int LEVELS         = 3;
    localparam int CFG_INDEX_BITS = 3;
    localparam int WIDEST_A       = (INDEX_BITS > SCALE_BITS) ? INDEX_BITS : SCALE_BITS;
    localparam int WIDEST_B       = (PRESCALE_BITS > ORDER_BITS) ? PRESCALE_BITS : ORDER_BITS;
    localparam int CFG_DATA_BITS  = (WIDEST_A > WIDEST_B) ? WIDEST_A : WIDEST_B;

    typedef logic [INDEX_BITS-1:0]    index_t;
    typedef logic [PRESCALE_BITS-1:0] prescale_t;
    typedef logic [SCALE_BITS-1:0]    scale_t;
    typedef logic [ORDER_BITS-1:0]    order_t;
    typedef logic [OFFSET_BITS-1:0]   offset_t;

    // axis code per loop level, the spare code drives z
    typedef enum logic [1:0] {
        AXIS_X     = 2'd0,
        AXIS_Y     = 2'd1,
        AXIS_Z     = 2'd2,
        AXIS_Z_ALT = 2'd3
    } axis_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_TICK_RATE  = 3'd0,
        REG_LOOP_ORDER = 3'd1,
        REG_LIMIT_X    = 3'd2,
        REG_LIMIT_Y    = 3'd3,
        REG_LIMIT_Z    = 3'd4,
        REG_SCALE_X    = 3'd5,
        REG_SCALE_Y    = 3'd6,
        REG_SCALE_Z    = 3'd7
    } cfg_index_t;

    localparam prescale_t TICK_RATE_RESET  = prescale_t'(1);
    localparam order_t    LOOP_ORDER_RESET = order_t'(36);
    localparam index_t    LIMIT_RESET      = '0;
    localparam scale_t    SCALE_RESET      = scale_t'(256);

    typedef struct packed {
        prescale_t tick_rate;
        order_t    loop_order;
        index_t    limit_x;
        index_t    limit_y;
        index_t    limit_z;
        scale_t    scale_x;
        scale_t    scale_y;
        scale_t    scale_z;
    } cfg_t;

    typedef struct packed {
        index_t index_x;
        index_t index_y;
        index_t index_z;
        logic   advanced;
    } step_item_t;

endpackage

@@ design/nested_loop_index_stepper.sv @@
// nested loop index stepper
//
// input channel: in_valid / in_stall carry one item, the pulse bit. a pulse
// of 1 advances the prescaler; when it reaches tick_rate the three-level
// loop nest steps once (innermost level first, axes picked by loop_order).
// a pulse of 0 leaves all state alone and still produces a result item.
// output channel: out_valid / out_stall carry exactly one result item per
// input item: the three indices, the scaled offsets (x, z in Q18.8 and -y
// signed with 8 fraction bits) and the advanced flag.
// an accepted item passes the nest step and index register, then the three
// multiplies and the output register.
// throughput is one item per cycle while in_stall is low; the output register
// and the step register form a two-deep pipe, so in_stall rises only when both
// hold an item and out_stall is high.
// config: plain write port (cfg_write, cfg_index, cfg_data), no read-back;
// write only while no item is in flight.
// reset: asynchronous, active low; clears prescaler, indices and the pipe,
// and loads register defaults (tick_rate 1, order x/y/z, limits 0, scales 1.0).
module nested_loop_index_stepper (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [nlis_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [nlis_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 pulse,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [nlis_pkg::INDEX_BITS-1:0]      index_x_out,
    output logic [nlis_pkg::INDEX_BITS-1:0]      index_y_out,
    output logic [nlis_pkg::INDEX_BITS-1:0]      index_z_out,
    output logic [nlis_pkg::OFFSET_BITS-1:0]     offset_x,
    output logic signed [nlis_pkg::OFFSET_BITS:0] offset_y,
    output logic [nlis_pkg::OFFSET_BITS-1:0]     offset_z,
    output logic                                 advanced
);
    import nlis_pkg::*;

    cfg_t       cfg;
    step_item_t item;
    logic       item_valid;
    logic       take;
    logic       in_accept;

    // stall only when the step register is full and cannot move on
    assign in_stall  = item_valid && !take;
    assign in_accept = in_valid && !in_stall;

    nlis_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // prescaler, loop nest state and the step register
    nlis_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_accept  (in_accept),
        .pulse      (pulse),
        .drain      (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // offset multiplies and the output register
    nlis_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .item_valid  (item_valid),
        .item        (item),
        .take        (take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .index_x_out (index_x_out),
        .index_y_out (index_y_out),
        .index_z_out (index_z_out),
        .offset_x    (offset_x),
        .offset_y    (offset_y),
        .offset_z    (offset_z),
        .advanced    (advanced)
    );

endmodule

@@ design/nlis_cfg.sv @@
module nlis_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [nlis_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [nlis_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output nlis_pkg::cfg_t                       cfg
);
    import nlis_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_rate  <= TICK_RATE_RESET;
            cfg_reg.loop_order <= LOOP_ORDER_RESET;
            cfg_reg.limit_x    <= LIMIT_RESET;
            cfg_reg.limit_y    <= LIMIT_RESET;
            cfg_reg.limit_z    <= LIMIT_RESET;
            cfg_reg.scale_x    <= SCALE_RESET;
            cfg_reg.scale_y    <= SCALE_RESET;
            cfg_reg.scale_z    <= SCALE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_TICK_RATE:  cfg_reg.tick_rate  <= cfg_data[PRESCALE_BITS-1:0];
                REG_LOOP_ORDER: cfg_reg.loop_order <= cfg_data[ORDER_BITS-1:0];
                REG_LIMIT_X:    cfg_reg.limit_x    <= cfg_data[INDEX_BITS-1:0];
                REG_LIMIT_Y:    cfg_reg.limit_y    <= cfg_data[INDEX_BITS-1:0];
                REG_LIMIT_Z:    cfg_reg.limit_z    <= cfg_data[INDEX_BITS-1:0];
                REG_SCALE_X:    cfg_reg.scale_x    <= cfg_data[SCALE_BITS-1:0];
                REG_SCALE_Y:    cfg_reg.scale_y    <= cfg_data[SCALE_BITS-1:0];
                REG_SCALE_Z:    cfg_reg.scale_z    <= cfg_data[SCALE_BITS-1:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/nlis_step.sv @@
module nlis_step (
    input  logic                  clk,
    input  logic                  rst_n,
    input  nlis_pkg::cfg_t        cfg,
    input  logic                  in_accept,
    input  logic                  pulse,
    input  logic                  drain,
    output logic                  item_valid,
    output nlis_pkg::step_item_t  item
);
    import nlis_pkg::*;

    prescale_t  prescale_reg;
    prescale_t  prescale_next;
    index_t     index_x_reg;
    index_t     index_y_reg;
    index_t     index_z_reg;
    index_t     index_x_next;
    index_t     index_y_next;
    index_t     index_z_next;
    logic       advance;
    logic       item_valid_reg;
    step_item_t item_reg;

    // prescaler: zero rate acts as one
    always_comb
    begin
        logic [PRESCALE_BITS:0] count_inc;
        logic [PRESCALE_BITS:0] rate;
        count_inc = {1'b0, prescale_reg} + 1'b1;
        rate      = (cfg.tick_rate == '0) ? (PRESCALE_BITS+1)'(1) : {1'b0, cfg.tick_rate};
        advance   = pulse && (count_inc >= rate);
        if (!pulse)
            prescale_next = prescale_reg;
        else if (advance)
            prescale_next = '0;
        else
            prescale_next = count_inc[PRESCALE_BITS-1:0];
    end

    // loop nest, innermost level first, on live indices
    always_comb
    begin
        index_t idx [LEVELS];
        index_t lim [LEVELS];
        logic   done;
        logic [1:0] sel;
        idx[0] = index_x_reg;
        idx[1] = index_y_reg;
        idx[2] = index_z_reg;
        lim[0] = cfg.limit_x;
        lim[1] = cfg.limit_y;
        lim[2] = cfg.limit_z;
        done   = 1'b0;
        for (int level = 0; level < LEVELS; level++)
        begin
            unique case (axis_t'(cfg.loop_order[2*level +: 2]))
                AXIS_X:     sel = 2'd0;
                AXIS_Y:     sel = 2'd1;
                AXIS_Z:     sel = 2'd2;
                AXIS_Z_ALT: sel = 2'd2;
            endcase
            if (!done)
            begin
                if (idx[sel] < lim[sel])
                begin
                    idx[sel] = idx[sel] + 1'b1;
                    done     = 1'b1;
                end
                else
                begin
                    idx[sel] = '0;
                end
            end
        end
        if (advance)
        begin
            index_x_next = idx[0];
            index_y_next = idx[1];
            index_z_next = idx[2];
        end
        else
        begin
            index_x_next = index_x_reg;
            index_y_next = index_y_reg;
            index_z_next = index_z_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg   <= '0;
            index_x_reg    <= '0;
            index_y_reg    <= '0;
            index_z_reg    <= '0;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                prescale_reg <= prescale_next;
                index_x_reg  <= index_x_next;
                index_y_reg  <= index_y_next;
                index_z_reg  <= index_z_next;
            end
            if (in_accept)
                item_valid_reg <= 1'b1;
            else if (drain)
                item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.index_x  <= index_x_next;
            item_reg.index_y  <= index_y_next;
            item_reg.index_z  <= index_z_next;
            item_reg.advanced <= advance;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

@@ design/nlis_scale.sv @@
module nlis_scale (
    input  logic                               clk,
    input  logic                               rst_n,
    input  nlis_pkg::cfg_t                     cfg,
    input  logic                               item_valid,
    input  nlis_pkg::step_item_t               item,
    output logic                               take,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [nlis_pkg::INDEX_BITS-1:0]    index_x_out,
    output logic [nlis_pkg::INDEX_BITS-1:0]    index_y_out,
    output logic [nlis_pkg::INDEX_BITS-1:0]    index_z_out,
    output logic [nlis_pkg::OFFSET_BITS-1:0]   offset_x,
    output logic signed [nlis_pkg::OFFSET_BITS:0] offset_y,
    output logic [nlis_pkg::OFFSET_BITS-1:0]   offset_z,
    output logic                               advanced
);
    import nlis_pkg::*;

    logic                  out_valid_reg;
    logic                  room;
    offset_t               prod_x;
    offset_t               prod_y;
    offset_t               prod_z;
    index_t                index_x_reg;
    index_t                index_y_reg;
    index_t                index_z_reg;
    offset_t               offset_x_reg;
    logic [OFFSET_BITS:0]  offset_y_reg;
    offset_t               offset_z_reg;
    logic                  advanced_reg;

    assign room = !out_valid_reg || !out_stall;
    assign take = item_valid && room;

    assign prod_x = OFFSET_BITS'(cfg.scale_x) * OFFSET_BITS'(item.index_x);
    assign prod_y = OFFSET_BITS'(cfg.scale_y) * OFFSET_BITS'(item.index_y);
    assign prod_z = OFFSET_BITS'(cfg.scale_z) * OFFSET_BITS'(item.index_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            index_x_reg  <= item.index_x;
            index_y_reg  <= item.index_y;
            index_z_reg  <= item.index_z;
            offset_x_reg <= prod_x;
            offset_y_reg <= '0 - {1'b0, prod_y};
            offset_z_reg <= prod_z;
            advanced_reg <= item.advanced;
        end
    end

    assign out_valid   = out_valid_reg;
    assign index_x_out = index_x_reg;
    assign index_y_out = index_y_reg;
    assign index_z_out = index_z_reg;
    assign offset_x    = offset_x_reg;
    assign offset_y    = offset_y_reg;
    assign offset_z    = offset_z_reg;
    assign advanced    = advanced_reg;

endmodule

@@ design/nlis_checker.sv @@
module nlis_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic [nlis_pkg::INDEX_BITS-1:0]      index_x_out,
    input logic [nlis_pkg::INDEX_BITS-1:0]      index_y_out,
    input logic [nlis_pkg::INDEX_BITS-1:0]      index_z_out,
    input logic [nlis_pkg::OFFSET_BITS-1:0]     offset_x,
    input logic signed [nlis_pkg::OFFSET_BITS:0] offset_y,
    input logic [nlis_pkg::OFFSET_BITS-1:0]     offset_z,
    input logic                                 advanced
);
    import nlis_pkg::*;

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(index_x_out) && $stable(index_y_out)
            && $stable(index_z_out) && $stable(offset_x) && $stable(offset_y)
            && $stable(offset_z) && $stable(advanced))
        else $error("stalled result changed");

    // input backpressure only comes from a full, stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // a zero index always gives a zero offset
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (index_x_out == '0 || index_y_out == '0 || index_z_out == '0)
            |-> (index_x_out != '0 || offset_x == '0)
             && (index_y_out != '0 || offset_y == '0)
             && (index_z_out != '0 || offset_z == '0))
        else $error("nonzero offset for zero index");

endmodule

bind nested_loop_index_stepper nlis_checker u_nlis_checker (.*);

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    import nlis_pkg::*;

    // expected position item, one per accepted pulse item
    typedef struct {
        index_t                      ix;
        index_t                      iy;
        index_t                      iz;
        offset_t                     ox;
        logic signed [OFFSET_BITS:0] oy;
        offset_t                     oz;
        logic                        adv;
    } position_t;

    // one line of the directed table: either a register write or an item,
    // an item may carry indices and the advanced flag typed in by hand
    typedef struct packed {
        logic                     is_write;
        cfg_index_t               sel;
        logic [CFG_DATA_BITS-1:0] value;
        logic                     pulse_bit;
        logic                     typed;
        step_item_t               known;
    } directed_row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_write;
    logic [CFG_INDEX_BITS-1:0]           cfg_index;
    logic [CFG_DATA_BITS-1:0]            cfg_data;
    logic                                in_valid;
    logic                                in_stall;
    logic                                pulse;
    logic                                out_valid;
    logic                                out_stall;
    logic [INDEX_BITS-1:0]               index_x_out;
    logic [INDEX_BITS-1:0]               index_y_out;
    logic [INDEX_BITS-1:0]               index_z_out;
    logic [OFFSET_BITS-1:0]              offset_x;
    logic signed [OFFSET_BITS:0]         offset_y;
    logic [OFFSET_BITS-1:0]              offset_z;
    logic                                advanced;

    // shadow of the register file and of the stepper state
    cfg_t      shadow_cfg;
    prescale_t prescale_count;
    index_t    nest_x;
    index_t    nest_y;
    index_t    nest_z;

    position_t pending_positions[$];
    int        mismatch_count;

    // chance in percent that a side idles before its next item
    int        in_idle_pct;
    int        out_idle_pct;

    nested_loop_index_stepper u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pulse       (pulse),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .index_x_out (index_x_out),
        .index_y_out (index_y_out),
        .index_z_out (index_z_out),
        .offset_x    (offset_x),
        .offset_y    (offset_y),
        .offset_z    (offset_z),
        .advanced    (advanced)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop in case a handshake hangs
    initial
    begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    // indices plus scaled offsets under the current scales
    function automatic position_t position_of(index_t ix, index_t iy, index_t iz, logic adv);
        position_t p;
        p.ix  = ix;
        p.iy  = iy;
        p.iz  = iz;
        p.ox  = offset_t'(shadow_cfg.scale_x) * offset_t'(ix);
        // y runs downward: negate the product in one extra bit
        p.oy  = '0 - {1'b0, offset_t'(shadow_cfg.scale_y) * offset_t'(iy)};
        p.oz  = offset_t'(shadow_cfg.scale_z) * offset_t'(iz);
        p.adv = adv;
        return p;
    endfunction

    // one step of the loop nest, innermost level first
    function automatic void step_nest();
        index_t idx [0:2];
        index_t lim [0:2];
        axis_t  ax;
        int     a;
        logic   done;
        idx[0] = nest_x;
        idx[1] = nest_y;
        idx[2] = nest_z;
        lim[0] = shadow_cfg.limit_x;
        lim[1] = shadow_cfg.limit_y;
        lim[2] = shadow_cfg.limit_z;
        done   = 1'b0;
        for (int level = 0; level < LEVELS; level++)
        begin
            if (!done)
            begin
                ax = axis_t'(shadow_cfg.loop_order[2*level +: 2]);
                case (ax)
                    AXIS_X:             a = 0;
                    AXIS_Y:             a = 1;
                    AXIS_Z, AXIS_Z_ALT: a = 2;
                    default:            a = 2;
                endcase
                // levels see the live indices, so a repeated axis sees its fresh wrap
                if (idx[a] < lim[a])
                begin
                    idx[a] = idx[a] + 1'b1;
                    done   = 1'b1;
                end
                else
                    idx[a] = '0;
            end
        end
        nest_x = idx[0];
        nest_y = idx[1];
        nest_z = idx[2];
    endfunction

    // prescaler then nest; a zero rate counts as one
    function automatic position_t predict_pulse(logic pulse_bit);
        prescale_t rate;
        int        next_count;
        logic      stepped;
        stepped = 1'b0;
        if (pulse_bit)
        begin
            rate       = (shadow_cfg.tick_rate == '0) ? prescale_t'(1) : shadow_cfg.tick_rate;
            next_count = int'(prescale_count) + 1;
            // a rate lowered below the running count fires at once
            if (next_count >= int'(rate))
            begin
                prescale_count = '0;
                step_nest();
                stepped = 1'b1;
            end
            else
                prescale_count = prescale_t'(next_count);
        end
        return position_of(nest_x, nest_y, nest_z, stepped);
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic int idle_cycles(int pct);
        return ($urandom_range(0, 99) < pct) ? $urandom_range(1, 15) : 0;
    endfunction

    function automatic directed_row_t reg_row(cfg_index_t sel, int value);
        directed_row_t r;
        r          = '0;
        r.is_write = 1'b1;
        r.sel      = sel;
        r.value    = CFG_DATA_BITS'(value);
        return r;
    endfunction

    function automatic directed_row_t pulse_row(logic p);
        directed_row_t r;
        r           = '0;
        r.pulse_bit = p;
        return r;
    endfunction

    function automatic directed_row_t known_row(logic p, int ix, int iy, int iz, logic adv);
        directed_row_t r;
        r                = '0;
        r.pulse_bit      = p;
        r.typed          = 1'b1;
        r.known.index_x  = index_t'(ix);
        r.known.index_y  = index_t'(iy);
        r.known.index_z  = index_t'(iz);
        r.known.advanced = adv;
        return r;
    endfunction

    // random register value; narrow registers sometimes get junk above their width
    function automatic logic [CFG_DATA_BITS-1:0] draw_setting(cfg_index_t sel, logic climb);
        logic [CFG_DATA_BITS-1:0] value;
        logic [CFG_DATA_BITS-1:0] junk;
        int                       pick;
        pick = $urandom_range(0, 9);
        junk = ($urandom_range(0, 3) == 0) ? CFG_DATA_BITS'($urandom) : '0;
        if (climb)
        begin
            // long run up the x axis at full scale
            case (sel)
                REG_TICK_RATE:            value = CFG_DATA_BITS'(1);
                REG_LOOP_ORDER:           value = CFG_DATA_BITS'(LOOP_ORDER_RESET);
                REG_LIMIT_X:              value = CFG_DATA_BITS'(index_t'('1));
                REG_LIMIT_Y, REG_LIMIT_Z: value = CFG_DATA_BITS'(3);
                default:                  value = CFG_DATA_BITS'(scale_t'('1));
            endcase
        end
        else
        begin
            case (sel)
                REG_TICK_RATE:
                begin
                    if (pick == 0)
                        value = '0;
                    else if (pick == 1)
                        value = CFG_DATA_BITS'(prescale_t'('1));
                    else if (pick < 4)
                        value = CFG_DATA_BITS'(prescale_t'($urandom));
                    else
                        value = CFG_DATA_BITS'($urandom_range(1, 3));
                    value = value | (junk << PRESCALE_BITS);
                end
                REG_LOOP_ORDER:
                    value = CFG_DATA_BITS'(order_t'($urandom)) | (junk << ORDER_BITS);
                REG_LIMIT_X, REG_LIMIT_Y, REG_LIMIT_Z:
                begin
                    // mostly tiny limits so the carries reach the outer levels
                    if (pick == 0)
                        value = CFG_DATA_BITS'(index_t'('1));
                    else if (pick == 1)
                        value = CFG_DATA_BITS'(index_t'($urandom));
                    else
                        value = CFG_DATA_BITS'($urandom_range(0, 3));
                    value = value | (junk << INDEX_BITS);
                end
                default:
                begin
                    if (pick == 0)
                        value = '0;
                    else if (pick == 1)
                        value = CFG_DATA_BITS'(scale_t'('1));
                    else
                        value = CFG_DATA_BITS'(scale_t'($urandom));
                end
            endcase
        end
        return value;
    endfunction

    // one register write, then the shadow copy follows
    task automatic write_reg(input cfg_index_t sel, input logic [CFG_DATA_BITS-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (sel)
            REG_TICK_RATE:  shadow_cfg.tick_rate  = value[PRESCALE_BITS-1:0];
            REG_LOOP_ORDER: shadow_cfg.loop_order = value[ORDER_BITS-1:0];
            REG_LIMIT_X:    shadow_cfg.limit_x    = value[INDEX_BITS-1:0];
            REG_LIMIT_Y:    shadow_cfg.limit_y    = value[INDEX_BITS-1:0];
            REG_LIMIT_Z:    shadow_cfg.limit_z    = value[INDEX_BITS-1:0];
            REG_SCALE_X:    shadow_cfg.scale_x    = value[SCALE_BITS-1:0];
            REG_SCALE_Y:    shadow_cfg.scale_y    = value[SCALE_BITS-1:0];
            REG_SCALE_Z:    shadow_cfg.scale_z    = value[SCALE_BITS-1:0];
            default:        ;
        endcase
    endtask

    // stop sending and wait for every expected item to come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_positions.size() != 0)
            @(posedge clk);
    endtask

    // one pulse item: optional idle gap, then hold until accepted
    task automatic send_item(input logic pulse_bit, input logic typed, input step_item_t known);
        int        gap;
        position_t want;
        gap = idle_cycles(in_idle_pct);
        // valid only drops when a gap follows, so back-to-back items keep it high
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pulse    <= pulse_bit;
        @(posedge clk);
        // in_stall read here is the value the edge saw
        while (in_stall)
            @(posedge clk);
        want = predict_pulse(pulse_bit);
        if (typed)
            want = position_of(known.index_x, known.index_y, known.index_z, known.advanced);
        pending_positions.push_back(want);
    endtask

    // ---------------------------------------------------------------
    // result side: random stall per item
    // ---------------------------------------------------------------
    initial
    begin : result_stall
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = idle_cycles(out_idle_pct);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // ---------------------------------------------------------------
    // checker: field by field against the oldest expectation
    // ---------------------------------------------------------------
    task automatic compare_field(input string name, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        position_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_positions.size() == 0)
            begin
                $display("%0t: item with nothing expected, indices %0d %0d %0d",
                         $time, index_x_out, index_y_out, index_z_out);
                mismatch_count++;
            end
            else
            begin
                want = pending_positions.pop_front();
                compare_field("index_x_out", 64'(want.ix), 64'(index_x_out));
                compare_field("index_y_out", 64'(want.iy), 64'(index_y_out));
                compare_field("index_z_out", 64'(want.iz), 64'(index_z_out));
                compare_field("offset_x", 64'(want.ox), 64'(offset_x));
                compare_field("offset_y", 64'(want.oy), 64'(offset_y));
                compare_field("offset_z", 64'(want.oz), 64'(offset_z));
                compare_field("advanced", 64'(want.adv), 64'(advanced));
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        directed_row_t rows[$];
        logic          climb;
        int            count;
        rows = '{
            // reset state: all limits 0, every pulse wraps the whole nest
            known_row(1'b0, 0, 0, 0, 1'b0),
            known_row(1'b1, 0, 0, 0, 1'b1),
            reg_row(REG_LIMIT_X, 1),
            reg_row(REG_LIMIT_Y, 1),
            reg_row(REG_LIMIT_Z, 1),
            reg_row(REG_SCALE_X, 16'hFFFF),
            reg_row(REG_SCALE_Y, 16'hFFFF),
            reg_row(REG_SCALE_Z, 16'hFFFF),
            // full binary count through a 2x2x2 nest at the largest scales
            known_row(1'b1, 1, 0, 0, 1'b1),
            known_row(1'b1, 0, 1, 0, 1'b1),
            known_row(1'b1, 1, 1, 0, 1'b1),
            known_row(1'b1, 0, 0, 1, 1'b1),
            // no pulse holds everything
            known_row(1'b0, 0, 0, 1, 1'b0),
            pulse_row(1'b1),
            pulse_row(1'b1),
            known_row(1'b1, 1, 1, 1, 1'b1),
            // all three levels wrap
            known_row(1'b1, 0, 0, 0, 1'b1),
            // zero rate behaves as one
            reg_row(REG_TICK_RATE, 0),
            known_row(1'b1, 1, 0, 0, 1'b1),
            // slowest rate: count builds up without a step
            reg_row(REG_TICK_RATE, 255),
            known_row(1'b1, 1, 0, 0, 1'b0),
            known_row(1'b1, 1, 0, 0, 1'b0),
            known_row(1'b1, 1, 0, 0, 1'b0),
            // rate dropped below the running count steps on the next pulse
            reg_row(REG_TICK_RATE, 2),
            known_row(1'b1, 0, 1, 0, 1'b1),
            // x on every level: a wrapped x is seen as 0 by the next level
            reg_row(REG_TICK_RATE, 1),
            reg_row(REG_LOOP_ORDER, 0),
            known_row(1'b1, 1, 1, 0, 1'b1),
            known_row(1'b1, 1, 1, 0, 1'b1),
            // y innermost with y above its limit, spare code on the outer levels
            reg_row(REG_LOOP_ORDER, 61),
            reg_row(REG_LIMIT_Y, 0),
            known_row(1'b1, 1, 0, 1, 1'b1),
            known_row(1'b1, 1, 0, 1, 1'b1),
            // spare code on every level
            reg_row(REG_LOOP_ORDER, 63),
            known_row(1'b1, 1, 0, 1, 1'b1)
        };

        // every input known from time zero while reset is held low
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = REG_TICK_RATE;
        cfg_data       = '0;
        in_valid       = 1'b0;
        pulse          = 1'b0;
        mismatch_count = 0;
        in_idle_pct    = 25;
        out_idle_pct   = 25;
        shadow_cfg     = '{TICK_RATE_RESET, LOOP_ORDER_RESET, LIMIT_RESET, LIMIT_RESET,
                           LIMIT_RESET, SCALE_RESET, SCALE_RESET, SCALE_RESET};
        prescale_count = '0;
        nest_x         = '0;
        nest_y         = '0;
        nest_z         = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (rows[i])
        begin
            if (rows[i].is_write)
            begin
                settle();
                write_reg(rows[i].sel, rows[i].value);
            end
            else
                send_item(rows[i].pulse_bit, rows[i].typed, rows[i].known);
        end

        // random phases; state carries over so limits and rates shift under it
        for (int phase = 0; phase < 7; phase++)
        begin
            climb = (phase == 2);
            settle();
            for (int r = int'(REG_TICK_RATE); r <= int'(REG_SCALE_Z); r++)
                write_reg(cfg_index_t'(r), draw_setting(cfg_index_t'(r), climb));
            in_idle_pct  = 25 * $urandom_range(0, 3);
            out_idle_pct = 25 * $urandom_range(0, 3);
            count        = climb ? 400 : 70;
            for (int n = 0; n < count; n++)
                send_item(climb || ($urandom_range(0, 3) != 0), 1'b0, '0);
        end

        // drain, then wait for any stray item
        settle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
